// File: src/assert_macros.svh
// Assertion macros shared by the page window mapper RTL.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// Clocked assertion that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("%m: assertion failed");

`endif

// File: src/ems_pwm_pkg.sv
// Package for the EMS page window mapper: command codes, item struct, constants.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package ems_pwm_pkg;

   // Item commands
   typedef enum logic [1:0] {
      CMD_PORT_RD = 2'd0,
      CMD_PORT_WR = 2'd1,
      CMD_MEM     = 2'd2,
      CMD_RSVD    = 2'd3
   } cmd_type;

   // Input item as held in the input register
   typedef struct packed {
      logic       valid;
      cmd_type    cmd;
      logic [15:0] port;
      logic [7:0] data;
      logic [19:0] addr;
   } item_type;

   // Four bytes, one per window
   typedef logic [3:0][7:0] win_bytes_type;

   // Window state handed to the translator
   typedef struct packed {
      win_bytes_type page;
      logic [3:0]    base_idx;
   } win_state_type;

   localparam logic [13:0] REG_PAGE     = 14'h208;
   localparam logic [13:0] REG_CTRL     = 14'h209;
   localparam logic [7:0]  PAGE_RESET   = 8'h7F;
   localparam win_bytes_type CTRL_RESET = {8'h00, 8'h80, 8'h80, 8'h80};
   localparam logic [7:0]  RD_NONE      = 8'hFF;
   localparam logic [14:0] LIVE_KB      = 15'd640;
   localparam logic [14:0] RAM_KB_RESET = 15'd640;
   localparam logic [20:0] XLATE_BASE   = 21'h0A0000;
   localparam logic [1:0]  WIN_REGION   = 2'b11;   // addr[19:18] of 0xC0000..0xFFFFF
   localparam logic [3:0]  IDX_BIAS     = 4'd4;

endpackage

// File: src/ems_ppage_window_mapper_core.sv
// Top level of the EMS page window mapper: input register, register file,
// translator, result register, APB-style CSR. Depends on ems_pwm_pkg,
// ems_pwm_regs, ems_pwm_xlate and assert_macros.svh.
//
//   channel   ports                       handshake
//   input     req_cmd/port/data/addr      start high, busy low at clock edge
//   result    rsp_read_data .. romext     rsp_valid high for one cycle
//   config    psel/penable/pwrite/paddr   APB write, pready tied high
//
// One item per clock; an item is taken into the input register, and its result is
// registered in the result registers, which drive the rsp ports.
// busy is always low; a port write is visible to the very next item.
// Reset (synchronous) restores page regs to 0x7F, ctrl regs to 80/80/80/00, RAM 640 KB.
// Results cannot be stalled; the receiver takes each one on its strobe.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ems_page_window_mapper_core (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [15:0] req_port,
   input  logic [7:0]  req_data,
   input  logic [19:0] req_addr,
   // result channel
   output logic        rsp_valid,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_window_hit,
   output logic [20:0] rsp_phys_addr,
   output logic        rsp_in_ram,
   output logic        rsp_romext_enable,
   // configuration
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   ems_pwm_pkg::item_type      item_ff, item_in;
   ems_pwm_pkg::win_state_type win_state;
   logic [14:0] ram_kb_ff, ram_kb_in;
   logic        ports_live;
   logic [7:0]  rd_data;
   logic        romext_next;
   logic        x_hit, x_in_ram;
   logic [20:0] x_phys;
   logic        rsp_valid_ff;
   logic [7:0]  read_data_ff;
   logic        window_hit_ff, in_ram_ff, romext_ff;
   logic [20:0] phys_addr_ff;
   logic        csr_wr;

   assign busy   = 1'b0;
   assign pready = 1'b1;

   // CSR: ram_size_kb at byte address 0
   assign csr_wr    = psel && penable && pwrite && (paddr[2] == 1'b0);
   assign ram_kb_in = csr_wr ? pwdata[14:0] : ram_kb_ff;
   assign prdata    = (paddr[2] == 1'b0) ? {17'b0, ram_kb_ff} : '0;
   assign ports_live = (ram_kb_ff > ems_pwm_pkg::LIVE_KB);

   // Input register
   always_comb begin
      item_in.valid = start && !busy;
      item_in.cmd   = ems_pwm_pkg::cmd_type'(req_cmd);
      item_in.port  = req_port;
      item_in.data  = req_data;
      item_in.addr  = req_addr;
   end

   ems_pwm_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .item        (item_ff),
      .ports_live  (ports_live),
      .rd_data     (rd_data),
      .romext_next (romext_next),
      .win_state   (win_state)
   );

   ems_pwm_xlate u_xlate (
      .is_mem      (item_ff.cmd == ems_pwm_pkg::CMD_MEM),
      .addr        (item_ff.addr),
      .win_state   (win_state),
      .ram_size_kb (ram_kb_ff),
      .window_hit  (x_hit),
      .phys_addr   (x_phys),
      .in_ram      (x_in_ram)
   );

   // Input register and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         ram_kb_ff     <= ems_pwm_pkg::RAM_KB_RESET;
      end else begin
         if (item_in.valid) begin
            item_ff <= item_in;
         end else begin
            item_ff.valid <= 1'b0;
         end
         rsp_valid_ff  <= item_ff.valid;
         ram_kb_ff     <= ram_kb_in;
      end
   end

   // Result payload registers
   always_ff @(posedge clock) begin
      if (item_ff.valid) begin
         read_data_ff  <= rd_data;
         window_hit_ff <= x_hit;
         phys_addr_ff  <= x_phys;
         in_ram_ff     <= x_in_ram;
         romext_ff     <= romext_next;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_data     = read_data_ff;
   assign rsp_window_hit    = window_hit_ff;
   assign rsp_phys_addr     = phys_addr_ff;
   assign rsp_in_ram        = in_ram_ff;
   assign rsp_romext_enable = romext_ff;

   `ASSERT_CLK(a_item_gives_result, clock, reset, item_ff.valid |=> rsp_valid)
   `ASSERT_CLK(a_hit_in_xlate_range, clock, reset, (rsp_valid && rsp_window_hit) |-> (rsp_phys_addr >= ems_pwm_pkg::XLATE_BASE))
   `ASSERT_ALWAYS(a_reset_clears_valid, clock, $past(reset) |-> !rsp_valid && !item_ff.valid)

endmodule

// File: src/ems_pwm_regs.sv
// Page and control register file with port decode, reads and writes.
// Depends on ems_pwm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ems_pwm_regs (
   input  logic                      clock,
   input  logic                      reset,
   input  ems_pwm_pkg::item_type     item,
   input  logic                      ports_live,
   output logic [7:0]                rd_data,
   output logic                      romext_next,
   output ems_pwm_pkg::win_state_type win_state
);

   ems_pwm_pkg::win_bytes_type page_ff, page_in;
   ems_pwm_pkg::win_bytes_type ctrl_ff, ctrl_in;
   logic [1:0]  win;
   logic [13:0] reg_sel;
   logic        hit_page, hit_ctrl;
   logic        do_wr;
   logic [3:0]  idx_next;

   assign win      = item.port[15:14];
   assign reg_sel  = item.port[13:0];
   assign hit_page = (reg_sel == ems_pwm_pkg::REG_PAGE);
   assign hit_ctrl = (reg_sel == ems_pwm_pkg::REG_CTRL);
   assign do_wr    = item.valid && (item.cmd == ems_pwm_pkg::CMD_PORT_WR) && ports_live;

   // Port read: register byte, or 0xFF when nothing decodes; 0 for items that are not port reads
   always_comb begin
      rd_data = '0;
      if (item.cmd == ems_pwm_pkg::CMD_PORT_RD) begin
         rd_data = ems_pwm_pkg::RD_NONE;
         if (ports_live && hit_page) begin
            rd_data = page_ff[win];
         end else if (ports_live && hit_ctrl) begin
            rd_data = ctrl_ff[win];
         end
      end
   end

   // Port write
   always_comb begin
      page_in = page_ff;
      ctrl_in = ctrl_ff;
      if (do_wr && hit_page) begin
         page_in[win] = item.data;
      end else if (do_wr && hit_ctrl) begin
         ctrl_in[win] = item.data;
      end
   end

   // Base index after this item's write, for the ROM-extension flag
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         idx_next[k] = ctrl_in[k][7];
      end
   end
   assign romext_next = (idx_next[3:2] != 2'b00) || (idx_next[1:0] == 2'b11);

   always_ff @(posedge clock) begin
      if (reset) begin
         page_ff <= {4{ems_pwm_pkg::PAGE_RESET}};
         ctrl_ff <= ems_pwm_pkg::CTRL_RESET;
      end else begin
         page_ff <= page_in;
         ctrl_ff <= ctrl_in;
      end
   end

   // Current window state for translation
   always_comb begin
      win_state.page = page_ff;
      for (int k = 0; k < 4; k++) begin
         win_state.base_idx[k] = ctrl_ff[k][7];
      end
   end

   `ASSERT_CLK(a_dead_ports_hold_page, clock, reset, !ports_live |=> $stable(page_ff))
   `ASSERT_CLK(a_dead_ports_hold_ctrl, clock, reset, !ports_live |=> $stable(ctrl_ff))

endmodule

// File: src/ems_pwm_xlate.sv
// Memory address translation through the four EMS windows.
// Depends on ems_pwm_pkg.
`timescale 1ns / 1ps

module ems_pwm_xlate (
   input  logic                       is_mem,
   input  logic [19:0]                addr,
   input  ems_pwm_pkg::win_state_type win_state,
   input  logic [14:0]                ram_size_kb,
   output logic                       window_hit,
   output logic [20:0]                phys_addr,
   output logic                       in_ram
);

   logic [1:0]  k;
   logic [7:0]  pg;
   logic [3:0]  rel;
   logic        hit;
   logic [20:0] phys;

   // Window k sits at 0xC0000 + k*16K + (((idx+4-k) & 0xC) << 14);
   // addr[15:14] already equals k, so only bits 19:16 need a match
   assign k   = addr[15:14];
   assign pg  = win_state.page[k];
   assign rel = win_state.base_idx + ems_pwm_pkg::IDX_BIAS - {2'b00, k};
   assign hit = pg[7] && (addr[19:18] == ems_pwm_pkg::WIN_REGION) &&
                (addr[17:16] == rel[3:2]);

   // Page bits 3:0 land at 17:14, page bit 6 at 18
   assign phys = hit ? ems_pwm_pkg::XLATE_BASE + {2'b00, pg[6], pg[3:0], addr[13:0]}
                     : {1'b0, addr};

   assign window_hit = is_mem && hit;
   assign phys_addr  = is_mem ? phys : '0;
   assign in_ram     = is_mem && ({4'b0000, phys} < {ram_size_kb, 10'b0});

endmodule
